// File: rtl/core/button_press_classifier_macros.svh
// Assertion shorthands for the button press classifier.
`ifndef BUTTON_PRESS_CLASSIFIER_MACROS_SVH
`define BUTTON_PRESS_CLASSIFIER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define BPC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("button_press_classifier: check failed");

// Next-cycle implication, disabled during reset.
`define BPC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("button_press_classifier: check failed");

`endif

// File: rtl/core/bpc_pkg.sv
`timescale 1ns / 1ps

package bpc_pkg;

  localparam int unsigned AdcW    = 10;
  localparam int unsigned PeriodW = 8;
  localparam int unsigned TimerW  = 16;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = 16;

  localparam logic [AdcW-1:0]    ThresholdRst = 10'd700;
  localparam logic [PeriodW-1:0] PeriodRst    = 8'd50;
  localparam logic [TimerW-1:0]  LongRst      = 16'd1000;
  localparam logic [TimerW-1:0]  WindowRst    = 16'd300;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_THRESHOLD = 2'd0,
    CFG_PERIOD    = 2'd1,
    CFG_LONG      = 2'd2,
    CFG_WINDOW    = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    CNT_IDLE   = 3'd0,
    CNT_FIRST  = 3'd1,
    CNT_SINGLE = 3'd4,
    CNT_LONG   = 3'd5,
    CNT_DOUBLE = 3'd6
  } press_cnt_e;

  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_SINGLE = 2'd1,
    EV_LONG   = 2'd2,
    EV_DOUBLE = 2'd3
  } press_ev_e;

  function automatic logic [TimerW-1:0] window_limit(logic [TimerW-1:0] long_ticks,
                                                      logic [TimerW-1:0] window);
    return (long_ticks >= window) ? long_ticks - window : '0;
  endfunction

endpackage

// File: rtl/core/button_press_classifier.sv
`timescale 1ns / 1ps

// Button press classifier. One item per millisecond tick, one result item per
// input item, in order. For each item, its state update and its result are
// computed in one pass of short logic and land in the state registers and the
// output register at the accepting edge, so a new item is taken every cycle
// while the output register is empty or being drained. Configuration (index 0
// threshold, 1 sample period, 2 long ticks, 3 double window) is to be written
// through cfg_we_i/cfg_idx_i/cfg_data_i while no item is in flight, which the
// block does not enforce; the long-ticks-minus-window limit is kept registered.
module button_press_classifier (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [bpc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [bpc_pkg::CfgW-1:0]     cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [bpc_pkg::AdcW-1:0]     adc_sample_i,
  input  logic                         clear_event_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [1:0]                   press_event_o,
  output logic                         button_down_o
);
  import bpc_pkg::*;

  logic [AdcW-1:0]    threshold_q;
  logic [PeriodW-1:0] period_q;
  logic [TimerW-1:0]  long_q, long_d;
  logic [TimerW-1:0]  window_q, window_d;
  logic [TimerW-1:0]  limit_q;

  logic [PeriodW-1:0] countdown_q, countdown_d;
  logic [TimerW-1:0]  timer_q, timer_d;
  press_cnt_e         cnt_q, cnt_d;
  logic               released_q, released_d;

  logic               out_valid_q;
  press_ev_e          event_q, event_d;
  logic               down_q;

  logic               in_acc;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_acc     = in_valid_i && in_ready_o;

  always_comb begin
    long_d   = long_q;
    window_d = window_q;
    if (cfg_we_i && cfg_idx_e'(cfg_idx_i) == CFG_LONG) long_d = cfg_data_i;
    if (cfg_we_i && cfg_idx_e'(cfg_idx_i) == CFG_WINDOW) window_d = cfg_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= ThresholdRst;
      period_q    <= PeriodRst;
      long_q      <= LongRst;
      window_q    <= WindowRst;
      limit_q     <= window_limit(LongRst, WindowRst);
    end else if (cfg_we_i) begin
      if (cfg_idx_e'(cfg_idx_i) == CFG_THRESHOLD) threshold_q <= cfg_data_i[AdcW-1:0];
      if (cfg_idx_e'(cfg_idx_i) == CFG_PERIOD) period_q <= cfg_data_i[PeriodW-1:0];
      long_q   <= long_d;
      window_q <= window_d;
      limit_q  <= window_limit(long_d, window_d);
    end
  end

  // One tick of the classifier.
  always_comb begin
    logic [PeriodW-1:0] cd_dec;
    logic               rel;
    logic [TimerW-1:0]  tmr;
    press_cnt_e         cnt;

    cnt = cnt_q;
    if (clear_event_i && cnt_q[2]) cnt = CNT_IDLE;

    tmr        = timer_q;
    released_d = released_q;
    cd_dec     = (countdown_q != '0) ? countdown_q - 1'b1 : '0;
    countdown_d = cd_dec;
    rel        = !(adc_sample_i > threshold_q);

    if (cd_dec == '0) begin
      countdown_d = period_q;
      if (released_q && !rel && !cnt[2]) begin
        // Count the press edge.
        if (cnt == CNT_IDLE) begin
          cnt = CNT_FIRST;
          tmr = long_q;
        end else begin
          cnt = (timer_q > limit_q) ? CNT_DOUBLE : CNT_SINGLE;
        end
      end
      if (cnt == CNT_FIRST && tmr == '0) cnt = CNT_LONG;
      if (cnt == CNT_FIRST && tmr < limit_q && rel) cnt = CNT_SINGLE;
      released_d = rel;
    end

    timer_d = (tmr != '0) ? tmr - 1'b1 : '0;
    cnt_d   = cnt;

    unique case (cnt)
      CNT_SINGLE: event_d = EV_SINGLE;
      CNT_LONG:   event_d = EV_LONG;
      CNT_DOUBLE: event_d = EV_DOUBLE;
      default:    event_d = EV_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      countdown_q <= '0;
      timer_q     <= '0;
      cnt_q       <= CNT_IDLE;
      released_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        countdown_q <= countdown_d;
        timer_q     <= timer_d;
        cnt_q       <= cnt_d;
        released_q  <= released_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      event_q <= event_d;
      down_q  <= !released_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign press_event_o = event_q;
  assign button_down_o = down_q;

endmodule

// File: rtl/core/bpc_checker.sv
`timescale 1ns / 1ps

`include "button_press_classifier_macros.svh"

module bpc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [1:0] press_event_o
);

  // An accepted item always leaves a result behind it.
  `BPC_ASSERT_NXT(a_accept_gives_result, clk_i, rst_ni, in_valid_i && in_ready_o, out_valid_o)

  // An empty output register never blocks the input.
  `BPC_ASSERT_IMP(a_ready_when_empty, clk_i, rst_ni, !out_valid_o, in_ready_o)

  // Hold a stalled result.
  `BPC_ASSERT_NXT(a_hold_stalled, clk_i, rst_ni, out_valid_o && !out_ready_i,
                  out_valid_o && $stable(press_event_o))

endmodule

bind button_press_classifier bpc_checker u_bpc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .press_event_o (press_event_o)
);

// File: dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import bpc_pkg::*;

  localparam int unsigned CycleLimit = 300000;
  localparam int unsigned IdlePct    = 36;

  typedef struct {
    logic [AdcW-1:0] adc;
    logic            clr;
  } tick_t;

  typedef struct {
    press_ev_e kind;
    logic      down;
  } press_out_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgW-1:0]     cfg_data_i;
  logic                in_valid_i;
  logic                in_ready_o;
  logic [AdcW-1:0]     adc_sample_i;
  logic                clear_event_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic [1:0]          press_event_o;
  logic                button_down_o;

  button_press_classifier dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .adc_sample_i  (adc_sample_i),
    .clear_event_i (clear_event_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .press_event_o (press_event_o),
    .button_down_o (button_down_o)
  );

  // Classifier copy: configuration and state.
  logic [AdcW-1:0]    thr_q    = ThresholdRst;
  logic [PeriodW-1:0] period_q = PeriodRst;
  logic [TimerW-1:0]  long_q   = LongRst;
  logic [TimerW-1:0]  window_q = WindowRst;

  logic [PeriodW-1:0] smp_cnt    = '0;
  logic [TimerW-1:0]  hold_timer = '0;
  press_cnt_e         press_st   = CNT_IDLE;
  logic               last_rel   = 1'b0;

  tick_t      pending_ticks[$];
  press_out_t expected_events[$];
  tick_t      nxt_tick;
  bit         tick_taken;
  bit         steady;
  int         mismatches;
  int unsigned cycles;

  function automatic void take_sample(logic rel);
    logic [TimerW-1:0] limit;
    limit = (long_q >= window_q) ? long_q - window_q : '0;
    if (last_rel && !rel) begin
      last_rel = 1'b0;
      if (press_st >= CNT_SINGLE) return;
      if (press_st == CNT_IDLE) begin
        press_st   = CNT_FIRST;
        hold_timer = long_q;
      end else if (press_st == CNT_FIRST) begin
        press_st = (hold_timer > limit) ? CNT_DOUBLE : CNT_SINGLE;
      end
    end
    if (press_st == CNT_FIRST && hold_timer == '0) press_st = CNT_LONG;
    if (press_st == CNT_FIRST && hold_timer < limit && rel) press_st = CNT_SINGLE;
    last_rel = rel;
  endfunction

  function automatic press_out_t classify_tick(logic [AdcW-1:0] adc, logic clr);
    press_out_t res;
    if (clr && press_st >= CNT_SINGLE) press_st = CNT_IDLE;
    if (smp_cnt != '0) smp_cnt = smp_cnt - 1'b1;
    if (smp_cnt == '0) begin
      smp_cnt = period_q;
      take_sample((adc > thr_q) ? 1'b0 : 1'b1);
    end
    if (hold_timer != '0) hold_timer = hold_timer - 1'b1;
    case (press_st)
      CNT_SINGLE: res.kind = EV_SINGLE;
      CNT_LONG:   res.kind = EV_LONG;
      CNT_DOUBLE: res.kind = EV_DOUBLE;
      default:    res.kind = EV_NONE;
    endcase
    res.down = ~last_rel;
    return res;
  endfunction

  task automatic flag_mismatch(string msg);
    mismatches++;
    $display("mismatch at cycle %0d: %s", cycles, msg);
  endtask

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  // Predict at the accepting edge.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) begin
      expected_events.push_back(classify_tick(adc_sample_i, clear_event_i));
      tick_taken = 1'b1;
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || tick_taken)) begin
      if (pending_ticks.size() != 0 && (steady || $urandom_range(99) >= IdlePct)) begin
        nxt_tick = pending_ticks.pop_front();
        in_valid_i    <= 1'b1;
        adc_sample_i  <= nxt_tick.adc;
        clear_event_i <= nxt_tick.clr;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
    tick_taken = 1'b0;
  end

  always @(negedge clk_i) begin
    if (rst_ni) out_ready_i <= steady || ($urandom_range(99) >= IdlePct);
  end

  always @(posedge clk_i) begin
    press_out_t exp_out;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_events.size() == 0) begin
        flag_mismatch($sformatf("unexpected item event=%0d down=%0b",
                                press_event_o, button_down_o));
      end else begin
        exp_out = expected_events.pop_front();
        if (press_event_o !== exp_out.kind)
          flag_mismatch($sformatf("press_event %0d, expected %0d",
                                  press_event_o, exp_out.kind));
        if (button_down_o !== exp_out.down)
          flag_mismatch($sformatf("button_down %0b, expected %0b",
                                  button_down_o, exp_out.down));
      end
    end
  end

  task automatic push_tick(int adc, bit clr);
    tick_t t;
    t.adc = adc[AdcW-1:0];
    t.clr = clr;
    pending_ticks.push_back(t);
  endtask

  // Wait until every item is through, then let the block go quiet.
  task automatic settle();
    while (pending_ticks.size() != 0 || in_valid_i || expected_events.size() != 0)
      @(posedge clk_i);
    repeat (5) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, int unsigned data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data[CfgW-1:0];
    case (idx)
      CFG_THRESHOLD: thr_q    = data[AdcW-1:0];
      CFG_PERIOD:    period_q = data[PeriodW-1:0];
      CFG_LONG:      long_q   = data[TimerW-1:0];
      default:       window_q = data[TimerW-1:0];
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_config(int unsigned thr, int unsigned per, int unsigned lng,
                            int unsigned win);
    settle();
    write_reg(CFG_THRESHOLD, thr);
    write_reg(CFG_PERIOD, per);
    write_reg(CFG_LONG, lng);
    write_reg(CFG_WINDOW, win);
    repeat (3) @(posedge clk_i);
  endtask

  // Button waveform: alternating held/released stretches with noisy readings.
  task automatic button_phase(int unsigned thr, int unsigned per, int unsigned lng,
                              int unsigned win, int n, bit no_gaps);
    int  left;
    int  len;
    int  spt;
    int  r;
    int  adc;
    bit  held;
    set_config(thr, per, lng, win);
    steady = no_gaps;
    @(posedge clk_i);
    left = n;
    held = $urandom_range(1);
    spt  = (per == 0) ? 1 : per;
    while (left > 0) begin
      held = ~held;
      r = $urandom_range(9);
      if (r < 5) len = spt * $urandom_range(3, 1);
      else if (r < 8) len = spt * $urandom_range(8, 1);
      else len = lng + spt * $urandom_range(4, 1);
      if (len > left) len = left;
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(9) == 0) adc = $urandom_range(1023, 0);
        else if (held && thr < 1023) adc = $urandom_range(1023, thr + 1);
        else if (held) adc = $urandom_range(1023, 0);
        else adc = $urandom_range(thr, 0);
        push_tick(adc, $urandom_range(11) == 0);
      end
      left -= len;
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CFG_THRESHOLD;
    cfg_data_i    = '0;
    in_valid_i    = 1'b0;
    adc_sample_i  = '0;
    clear_event_i = 1'b0;
    out_ready_i   = 1'b0;
    steady        = 1'b0;
    mismatches    = 0;
    cycles        = 0;
    tick_taken    = 1'b0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(posedge clk_i);

    // Held at the first sample after reset: not a press. Clear with nothing pending.
    push_tick(1023, 0);
    push_tick(0, 1);
    push_tick(512, 0);

    // Sample every tick, zero long ticks: a press is a long press at once.
    set_config(500, 0, 0, 0);
    push_tick(0, 0);
    push_tick(1023, 0);
    push_tick(0, 0);
    push_tick(1023, 0);
    push_tick(1023, 1);
    push_tick(0, 0);

    // Window wider than long ticks: second press is a double.
    set_config(500, 1, 3, 10);
    push_tick(1023, 0);
    push_tick(0, 0);
    push_tick(1023, 0);
    push_tick(0, 1);

    // Release after the window gives a single; hold to timeout gives a long.
    set_config(500, 1, 4, 1);
    push_tick(1023, 0);
    push_tick(0, 0);
    push_tick(0, 0);
    push_tick(0, 1);
    push_tick(1023, 0);
    push_tick(1023, 0);
    push_tick(1023, 0);
    push_tick(1023, 0);
    push_tick(1023, 0);

    button_phase(700, 1, 20, 8, 250, 0);
    button_phase(512, 2, 40, 10, 250, 1);
    button_phase(0, 1, 12, 30, 200, 0);
    button_phase(1023, 3, 30, 0, 150, 0);
    button_phase(300, 0, 0, 0, 150, 0);
    button_phase(900, 255, 65535, 65535, 150, 0);
    button_phase(600, 1, 16, 15, 450, 0);

    settle();
    repeat (10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
